// ===== rtl/assert_macros.svh =====
// assertion helpers for the convolution engine checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while reset is active
`define M3_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked while reset is active
`define M3_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/m3conv_pkg.sv =====
package m3conv_pkg;

  localparam int INPUT_WORDS  = 4096;
  localparam int FILTER_WORDS = 1024;
  localparam int MAX_CHANNELS = 16;

  localparam int IN_AW    = $clog2(INPUT_WORDS);
  localparam int FLT_AW   = $clog2(FILTER_WORDS);
  localparam int CH_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CH_CNT_W = $clog2(MAX_CHANNELS + 1);

  localparam int CFG_W     = 36;
  localparam int CFG_IDX_W = 2;
  localparam int CC_W      = 5;
  localparam int SAMPLE_W  = 16;
  localparam int PROD_W    = 2 * SAMPLE_W;
  localparam int SUM_W     = 48;
  localparam int COORD_W   = 14;
  localparam int TAP_W     = 4;

  localparam logic [CFG_W-1:0] SETUP_RESET = 36'd37121;
  localparam logic [CC_W-1:0]  CC_RESET    = 5'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_Y   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_Z   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd3;

  localparam logic [1:0] CMD_WRITE_INPUT  = 2'd0;
  localparam logic [1:0] CMD_WRITE_FILTER = 2'd1;
  localparam logic [1:0] CMD_COMPUTE      = 2'd2;

  typedef struct packed {
    logic [1:0]                 command;
    logic [11:0]                address;
    logic signed [SAMPLE_W-1:0] sample;
    logic [7:0]                 out_x;
    logic [7:0]                 out_y;
    logic [7:0]                 out_z;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic                    out_of_grid;
  } out_item_t;

  typedef struct packed {
    logic [7:0]       size;
    logic [TAP_W-1:0] taps;
    logic [2:0]       stride;
    logic [2:0]       dil;
    logic signed [8:0] pad_b;
    logic signed [8:0] pad_e;
  } axis_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin;
    logic                      ok;
  } place_t;

  typedef struct packed {
    logic wr_input;
    logic wr_filter;
    logic capture;
    logic origin;
    logic prep1;
    logic prep2;
    logic load;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic grid_ok;
    logic empty;
    logic last_tap;
    logic pipe_idle;
  } dp_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ORIGIN,
    ST_PREP1,
    ST_PREP2,
    ST_LOAD,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  function automatic axis_t unpack_axis(logic [CFG_W-1:0] v);
    axis_t a;
    a.size   = v[7:0];
    a.taps   = v[11:8];
    a.stride = v[14:12];
    a.dil    = v[17:15];
    a.pad_b  = $signed(v[26:18]);
    a.pad_e  = $signed(v[35:27]);
    return a;
  endfunction

endpackage

// ===== rtl/m3conv_ctrl.sv =====
module m3conv_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [1:0]             command_i,
  input  m3conv_pkg::dp_status_t status_i,
  output m3conv_pkg::dp_cmd_t    cmd_o,
  output logic                   busy_o,
  output logic                   done_o
);

  m3conv_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= m3conv_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      m3conv_pkg::ST_IDLE: begin
        if (start_i && (command_i == m3conv_pkg::CMD_COMPUTE)) begin
          state_d = m3conv_pkg::ST_ORIGIN;
        end
      end
      m3conv_pkg::ST_ORIGIN: state_d = m3conv_pkg::ST_PREP1;
      m3conv_pkg::ST_PREP1: begin
        if (!status_i.grid_ok || status_i.empty) begin
          state_d = m3conv_pkg::ST_DONE;
        end else begin
          state_d = m3conv_pkg::ST_PREP2;
        end
      end
      m3conv_pkg::ST_PREP2: state_d = m3conv_pkg::ST_LOAD;
      m3conv_pkg::ST_LOAD:  state_d = m3conv_pkg::ST_RUN;
      m3conv_pkg::ST_RUN: begin
        if (status_i.last_tap) begin
          state_d = m3conv_pkg::ST_DRAIN;
        end
      end
      m3conv_pkg::ST_DRAIN: begin
        if (status_i.pipe_idle) begin
          state_d = m3conv_pkg::ST_DONE;
        end
      end
      m3conv_pkg::ST_DONE: state_d = m3conv_pkg::ST_IDLE;
      default: state_d = m3conv_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = (state_q != m3conv_pkg::ST_IDLE);
    done_o = (state_q == m3conv_pkg::ST_DONE);
    unique case (state_q)
      m3conv_pkg::ST_IDLE: begin
        cmd_o.wr_input  = start_i && (command_i == m3conv_pkg::CMD_WRITE_INPUT);
        cmd_o.wr_filter = start_i && (command_i == m3conv_pkg::CMD_WRITE_FILTER);
        cmd_o.capture   = start_i && (command_i == m3conv_pkg::CMD_COMPUTE);
      end
      m3conv_pkg::ST_ORIGIN: cmd_o.origin = 1'b1;
      m3conv_pkg::ST_PREP1:  cmd_o.prep1  = 1'b1;
      m3conv_pkg::ST_PREP2:  cmd_o.prep2  = 1'b1;
      m3conv_pkg::ST_LOAD:   cmd_o.load   = 1'b1;
      m3conv_pkg::ST_RUN:    cmd_o.step   = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== rtl/m3conv_dp.sv =====
module m3conv_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [m3conv_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [m3conv_pkg::CFG_W-1:0]          cfg_data_i,
  input  m3conv_pkg::in_item_t                  in_i,
  input  m3conv_pkg::dp_cmd_t                   cmd_i,
  output m3conv_pkg::dp_status_t                status_o,
  output m3conv_pkg::out_item_t                 result_o
);

  localparam int IN_AW    = m3conv_pkg::IN_AW;
  localparam int FLT_AW   = m3conv_pkg::FLT_AW;
  localparam int CH_W     = m3conv_pkg::CH_W;
  localparam int CH_CNT_W = m3conv_pkg::CH_CNT_W;
  localparam int COORD_W  = m3conv_pkg::COORD_W;
  localparam int SAMPLE_W = m3conv_pkg::SAMPLE_W;
  localparam int PROD_W   = m3conv_pkg::PROD_W;
  localparam int SUM_W    = m3conv_pkg::SUM_W;
  localparam int TAP_W    = m3conv_pkg::TAP_W;

  function automatic m3conv_pkg::place_t place_axis(m3conv_pkg::axis_t a, logic [7:0] idx);
    m3conv_pkg::place_t        p;
    logic [COORD_W-1:0]        scaled;
    logic signed [COORD_W-1:0] span;
    logic signed [COORD_W-1:0] last;
    logic signed [COORD_W-1:0] pb_ext;
    logic signed [COORD_W-1:0] pe_ext;
    scaled   = COORD_W'(idx) * COORD_W'(a.stride);
    pb_ext   = {{(COORD_W-9){a.pad_b[8]}}, a.pad_b};
    pe_ext   = {{(COORD_W-9){a.pad_e[8]}}, a.pad_e};
    span     = ($signed(COORD_W'(a.taps)) - $signed(COORD_W'(1)))
               * $signed(COORD_W'(a.dil)) + $signed(COORD_W'(1));
    last     = pe_ext + $signed(COORD_W'(a.size)) - span;
    p.origin = $signed(scaled) - pb_ext;
    p.ok     = (p.origin <= last);
    return p;
  endfunction

  // configuration
  logic [m3conv_pkg::CFG_W-1:0] ax_cfg_q, ay_cfg_q, az_cfg_q;
  logic [m3conv_pkg::CC_W-1:0]  cc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_cfg_q <= m3conv_pkg::SETUP_RESET;
      ay_cfg_q <= m3conv_pkg::SETUP_RESET;
      az_cfg_q <= m3conv_pkg::SETUP_RESET;
      cc_q     <= m3conv_pkg::CC_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        m3conv_pkg::CFG_AXIS_X:   ax_cfg_q <= cfg_data_i;
        m3conv_pkg::CFG_AXIS_Y:   ay_cfg_q <= cfg_data_i;
        m3conv_pkg::CFG_AXIS_Z:   az_cfg_q <= cfg_data_i;
        m3conv_pkg::CFG_CHANNELS: cc_q     <= cfg_data_i[m3conv_pkg::CC_W-1:0];
      endcase
    end
  end

  m3conv_pkg::axis_t ax, ay, az;
  assign ax = m3conv_pkg::unpack_axis(ax_cfg_q);
  assign ay = m3conv_pkg::unpack_axis(ay_cfg_q);
  assign az = m3conv_pkg::unpack_axis(az_cfg_q);

  // captured grid point and window origin
  logic [7:0]                ix_q, iy_q, iz_q;
  logic signed [COORD_W-1:0] ox_q, oy_q, oz_q;
  logic                      grid_ok_q, empty_q;
  logic [CH_CNT_W-1:0]       nch_q;
  m3conv_pkg::place_t        px, py, pz;
  logic [CH_CNT_W-1:0]       nch_d;

  assign px    = place_axis(ax, ix_q);
  assign py    = place_axis(ay, iy_q);
  assign pz    = place_axis(az, iz_q);
  assign nch_d = (32'(cc_q) > 32'(m3conv_pkg::MAX_CHANNELS)) ?
                 CH_CNT_W'(m3conv_pkg::MAX_CHANNELS) : CH_CNT_W'(cc_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ix_q <= in_i.out_x;
      iy_q <= in_i.out_y;
      iz_q <= in_i.out_z;
    end
    if (cmd_i.origin) begin
      ox_q <= px.origin;
      oy_q <= py.origin;
      oz_q <= pz.origin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_ok_q <= 1'b1;
      empty_q   <= 1'b0;
      nch_q     <= '0;
    end else if (cmd_i.origin) begin
      grid_ok_q <= px.ok && py.ok && pz.ok;
      empty_q   <= (nch_d == '0) || (ax.taps == '0) || (ay.taps == '0) || (az.taps == '0);
      nch_q     <= nch_d;
    end
  end

  // address steps, modulo the input store depth
  logic [IN_AW-1:0] sxy_q, tzy_q, stepy_q, stepz_q, stepc_q, ia0_q;
  logic [IN_AW-1:0] stepx;

  assign stepx = IN_AW'(ax.dil);

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep1) begin
      sxy_q <= IN_AW'(ax.size) * IN_AW'(ay.size);
      tzy_q <= IN_AW'(oz_q) * IN_AW'(ay.size) + IN_AW'(oy_q);
    end
    if (cmd_i.prep2) begin
      stepy_q <= IN_AW'(ay.dil) * IN_AW'(ax.size);
      stepz_q <= IN_AW'(az.dil) * sxy_q;
      stepc_q <= IN_AW'(az.size) * sxy_q;
      ia0_q   <= tzy_q * IN_AW'(ax.size) + IN_AW'(ox_q);
    end
  end

  // tap walk
  logic [TAP_W-1:0]          fx_q, fy_q, fz_q;
  logic [CH_W-1:0]           ch_q;
  logic [FLT_AW-1:0]         fa_q;
  logic signed [COORD_W-1:0] rx_q, ry_q, rz_q;
  logic [IN_AW-1:0]          a_c_q, a_z_q, a_y_q, a_x_q;
  logic                      end_x, end_y, end_z, end_c;
  logic                      in_x, in_y, in_z, tap_valid;
  logic signed [COORD_W-1:0] dx, dy, dz;

  assign dx    = $signed(COORD_W'(ax.dil));
  assign dy    = $signed(COORD_W'(ay.dil));
  assign dz    = $signed(COORD_W'(az.dil));
  assign end_x = (fx_q == ax.taps - TAP_W'(1));
  assign end_y = (fy_q == ay.taps - TAP_W'(1));
  assign end_z = (fz_q == az.taps - TAP_W'(1));
  assign end_c = (CH_CNT_W'(ch_q) == nch_q - CH_CNT_W'(1));

  assign in_x = !rx_q[COORD_W-1] && (rx_q[COORD_W-2:0] < (COORD_W-1)'(ax.size));
  assign in_y = !ry_q[COORD_W-1] && (ry_q[COORD_W-2:0] < (COORD_W-1)'(ay.size));
  assign in_z = !rz_q[COORD_W-1] && (rz_q[COORD_W-2:0] < (COORD_W-1)'(az.size));
  assign tap_valid = in_x && in_y && in_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_q <= '0;
      fy_q <= '0;
      fz_q <= '0;
      ch_q <= '0;
      fa_q <= '0;
    end else if (cmd_i.load) begin
      fx_q <= '0;
      fy_q <= '0;
      fz_q <= '0;
      ch_q <= '0;
      fa_q <= '0;
    end else if (cmd_i.step) begin
      fa_q <= fa_q + FLT_AW'(1);
      if (!end_x) begin
        fx_q <= fx_q + TAP_W'(1);
      end else if (!end_y) begin
        fx_q <= '0;
        fy_q <= fy_q + TAP_W'(1);
      end else if (!end_z) begin
        fx_q <= '0;
        fy_q <= '0;
        fz_q <= fz_q + TAP_W'(1);
      end else begin
        fx_q <= '0;
        fy_q <= '0;
        fz_q <= '0;
        ch_q <= ch_q + CH_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rx_q  <= ox_q;
      ry_q  <= oy_q;
      rz_q  <= oz_q;
      a_c_q <= ia0_q;
      a_z_q <= ia0_q;
      a_y_q <= ia0_q;
      a_x_q <= ia0_q;
    end else if (cmd_i.step) begin
      if (!end_x) begin
        rx_q  <= rx_q + dx;
        a_x_q <= a_x_q + stepx;
      end else if (!end_y) begin
        rx_q  <= ox_q;
        ry_q  <= ry_q + dy;
        a_y_q <= a_y_q + stepy_q;
        a_x_q <= a_y_q + stepy_q;
      end else if (!end_z) begin
        rx_q  <= ox_q;
        ry_q  <= oy_q;
        rz_q  <= rz_q + dz;
        a_z_q <= a_z_q + stepz_q;
        a_y_q <= a_z_q + stepz_q;
        a_x_q <= a_z_q + stepz_q;
      end else begin
        rx_q  <= ox_q;
        ry_q  <= oy_q;
        rz_q  <= oz_q;
        a_c_q <= a_c_q + stepc_q;
        a_z_q <= a_c_q + stepc_q;
        a_y_q <= a_c_q + stepc_q;
        a_x_q <= a_c_q + stepc_q;
      end
    end
  end

  // stores
  logic [SAMPLE_W-1:0] in_mem  [m3conv_pkg::INPUT_WORDS];
  logic [SAMPLE_W-1:0] flt_mem [m3conv_pkg::FILTER_WORDS];
  logic signed [SAMPLE_W-1:0] in_rd_q, flt_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_input) begin
      in_mem[in_i.address[IN_AW-1:0]] <= in_i.sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      in_rd_q <= $signed(in_mem[a_x_q]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_filter) begin
      flt_mem[in_i.address[FLT_AW-1:0]] <= in_i.sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      flt_rd_q <= $signed(flt_mem[fa_q]);
    end
  end

  // multiply and accumulate
  logic                     v1_q, v2_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SUM_W-1:0]  acc_q;

  always_ff @(posedge clk_i) begin
    prod_q <= in_rd_q * flt_rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      v1_q <= cmd_i.step && tap_valid;
      v2_q <= v1_q;
      if (cmd_i.capture) begin
        acc_q <= '0;
      end else if (v2_q) begin
        acc_q <= acc_q + {{(SUM_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
      end
    end
  end

  assign status_o.grid_ok   = grid_ok_q;
  assign status_o.empty     = empty_q;
  assign status_o.last_tap  = end_x && end_y && end_z && end_c;
  assign status_o.pipe_idle = !v1_q && !v2_q;

  assign result_o.sum         = acc_q;
  assign result_o.out_of_grid = !grid_ok_q;

endmodule

// ===== rtl/multichannel_3d_convolution_engine.sv =====
// channel   direction  handshake           payload
// command   in         start_i / busy_o    in_i (in_item_t)
// result    out        done_o strobe       result_o (out_item_t)
// config    in         cfg_we_i            cfg_index_i, cfg_data_i
//
// write commands are taken while idle; busy_o stays low and the next item may follow at once
// a compute walks N = channels * taps_z * taps_y * taps_x taps,
// one tap per cycle through the sample store read port and one multiplier
// a point off the output grid, zero channels or zero taps gives its result without walking any taps
// the result shows on result_o for the single cycle done_o is high; no stall from the receiver
// reset clears control and sets the configuration to a unit setup; the stores hold no reset value
module multichannel_3d_convolution_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  m3conv_pkg::in_item_t              in_i,
  output logic                              done_o,
  output m3conv_pkg::out_item_t             result_o,
  input  logic                              cfg_we_i,
  input  logic [m3conv_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [m3conv_pkg::CFG_W-1:0]      cfg_data_i
);

  m3conv_pkg::dp_cmd_t    dp_cmd;
  m3conv_pkg::dp_status_t dp_status;

  m3conv_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (in_i.command),
    .status_i  (dp_status),
    .cmd_o     (dp_cmd),
    .busy_o    (busy_o),
    .done_o    (done_o)
  );

  m3conv_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .result_o    (result_o)
  );

endmodule

// ===== rtl/m3conv_checker.sv =====
`include "assert_macros.svh"

module m3conv_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start_i,
  input logic                  busy_o,
  input m3conv_pkg::in_item_t  in_i,
  input logic                  done_o,
  input m3conv_pkg::out_item_t result_o
);

  logic compute_acc;
  assign compute_acc = start_i && !busy_o && (in_i.command == m3conv_pkg::CMD_COMPUTE);

  `M3_ASSERT_IMP(a_done_busy, clk_i, rst_ni, done_o, busy_o, "result outside a compute")
  `M3_ASSERT_NXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o, "result strobe longer than one cycle")
  `M3_ASSERT_NXT(a_done_free, clk_i, rst_ni, done_o, !busy_o, "block still busy after result")
  `M3_ASSERT_NXT(a_compute_busy, clk_i, rst_ni, compute_acc, busy_o, "compute not started")
  `M3_ASSERT_IMP(a_off_grid_zero, clk_i, rst_ni, done_o && result_o.out_of_grid, result_o.sum == '0, "off-grid result with nonzero sum")

endmodule

bind multichannel_3d_convolution_engine m3conv_checker u_m3conv_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .in_i     (in_i),
  .done_o   (done_o),
  .result_o (result_o)
);

// ===== bench/multichannel_3d_convolution_engine_tb.sv =====
`timescale 1ns / 100ps

module multichannel_3d_convolution_engine_tb;

  localparam int CFG_IDX_W    = m3conv_pkg::CFG_IDX_W;
  localparam int CFG_W        = m3conv_pkg::CFG_W;
  localparam int CC_W         = m3conv_pkg::CC_W;
  localparam int SAMPLE_W     = m3conv_pkg::SAMPLE_W;
  localparam int SUM_W        = m3conv_pkg::SUM_W;
  localparam int INPUT_WORDS  = m3conv_pkg::INPUT_WORDS;
  localparam int FILTER_WORDS = m3conv_pkg::FILTER_WORDS;
  localparam int MAX_CHANNELS = m3conv_pkg::MAX_CHANNELS;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 580;
  localparam int IDLE_WAIT = 4;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    longint size;
    longint taps;
    longint stride;
    longint dil;
    longint pad_b;
    longint pad_e;
  } span_t;

  typedef struct {
    bit                     is_cfg;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_W-1:0]       reg_val;
    m3conv_pkg::in_item_t   item;
    bit                     typed;
    m3conv_pkg::out_item_t  want;
  } step_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  m3conv_pkg::in_item_t  in_i;
  logic                  done_o;
  m3conv_pkg::out_item_t result_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_W-1:0]      cfg_data_i;

  logic signed [SAMPLE_W-1:0] in_mem [INPUT_WORDS];
  logic signed [SAMPLE_W-1:0] flt_mem [FILTER_WORDS];
  bit                         in_seen [INPUT_WORDS];
  bit                         flt_seen [FILTER_WORDS];
  logic [CFG_W-1:0]           span_reg [3];
  logic [CC_W-1:0]            chan_cnt;

  m3conv_pkg::out_item_t due_points [$];
  m3conv_pkg::out_item_t due_head;
  step_t                 plan [$];
  int                    need_in_q [$];
  int                    need_flt_q [$];
  int                    fail_cnt;
  int                    items_done;
  int                    quiet_cycles;
  bit                    burst;

  multichannel_3d_convolution_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .in_i        (in_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void add_row(step_t r);
    plan.insert(plan.size(), r);
  endfunction

  function automatic logic [CFG_W-1:0] span_word(int size, int taps, int stride, int dil,
                                                 int pad_b, int pad_e);
    return {pad_e[8:0], pad_b[8:0], dil[2:0], stride[2:0], taps[3:0], size[7:0]};
  endfunction

  function automatic span_t decode_span(logic [CFG_W-1:0] w);
    span_t s;
    s.size   = w[7:0];
    s.taps   = w[11:8];
    s.stride = w[14:12];
    s.dil    = w[17:15];
    s.pad_b  = longint'($signed(w[26:18]));
    s.pad_e  = longint'($signed(w[35:27]));
    return s;
  endfunction

  // walks the window of one output point; either sums it or lists unwritten words
  function automatic m3conv_pkg::out_item_t conv_point(m3conv_pkg::in_item_t itm,
                                                       bit note_missing);
    span_t                 sp [3];
    longint                org [3];
    longint                idx [3];
    longint                acc, nch, ch, fz, fy, fx, rz, ry, rx, ia, fa;
    bit                    on_grid;
    m3conv_pkg::out_item_t res;
    idx[0] = itm.out_x;
    idx[1] = itm.out_y;
    idx[2] = itm.out_z;
    on_grid = 1'b1;
    acc = 0;
    for (int a = 0; a < 3; a++) begin
      sp[a] = decode_span(span_reg[a]);
      org[a] = idx[a] * sp[a].stride - sp[a].pad_b;
      if (org[a] > sp[a].pad_e + sp[a].size - ((sp[a].taps - 1) * sp[a].dil + 1))
        on_grid = 1'b0;
    end
    nch = (chan_cnt > MAX_CHANNELS) ? MAX_CHANNELS : chan_cnt;
    if (on_grid) begin
      for (ch = 0; ch < nch; ch++) begin
        for (fz = 0; fz < sp[2].taps; fz++) begin
          rz = org[2] + fz * sp[2].dil;
          if (rz < 0 || rz >= sp[2].size) continue;
          for (fy = 0; fy < sp[1].taps; fy++) begin
            ry = org[1] + fy * sp[1].dil;
            if (ry < 0 || ry >= sp[1].size) continue;
            for (fx = 0; fx < sp[0].taps; fx++) begin
              rx = org[0] + fx * sp[0].dil;
              if (rx < 0 || rx >= sp[0].size) continue;
              ia = (((ch * sp[2].size + rz) * sp[1].size + ry) * sp[0].size + rx) % INPUT_WORDS;
              fa = (((ch * sp[2].taps + fz) * sp[1].taps + fy) * sp[0].taps + fx)
                   % FILTER_WORDS;
              if (note_missing) begin
                if (!in_seen[ia]) need_in_q.insert(need_in_q.size(), int'(ia));
                if (!flt_seen[fa]) need_flt_q.insert(need_flt_q.size(), int'(fa));
              end else begin
                acc += longint'(in_mem[ia]) * longint'(flt_mem[fa]);
              end
            end
          end
        end
      end
    end
    res.sum = acc[SUM_W-1:0];
    res.out_of_grid = ~on_grid;
    return res;
  endfunction

  function automatic logic [7:0] pick_index(logic [CFG_W-1:0] w);
    span_t  s;
    longint lim;
    s = decode_span(w);
    lim = s.pad_e + s.size - ((s.taps - 1) * s.dil + 1) + s.pad_b;
    if (lim < 0 || s.stride == 0 || lim / s.stride >= 255)
      return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, int'(lim / s.stride)));
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] random_span(bit few_taps);
    logic [CFG_W-1:0] w;
    int               taps;
    taps = few_taps ? $urandom_range(0, 1) :
           (($urandom_range(0, 3) == 0) ? 3 : $urandom_range(1, 2));
    w = {4'($urandom), 32'($urandom)};
    if ($urandom_range(0, 7) != 0)
      w = span_word($urandom_range(1, 10), taps, $urandom_range(0, 3), $urandom_range(0, 3),
                    int'($urandom_range(0, 4)) - 2, int'($urandom_range(0, 4)) - 2);
    w[11:8] = 4'(taps);
    return w;
  endfunction

  function automatic step_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    step_t s;
    s.is_cfg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    s.item    = '0;
    s.typed   = 1'b0;
    s.want    = '0;
    return s;
  endfunction

  function automatic step_t op_row(logic [1:0] cmd, int addr, int smp, int x, int y, int z);
    step_t s;
    s.is_cfg        = 1'b0;
    s.reg_idx       = '0;
    s.reg_val       = '0;
    s.item.command  = cmd;
    s.item.address  = 12'(addr);
    s.item.sample   = 16'(smp);
    s.item.out_x    = 8'(x);
    s.item.out_y    = 8'(y);
    s.item.out_z    = 8'(z);
    s.typed         = 1'b0;
    s.want          = '0;
    return s;
  endfunction

  function automatic step_t chk_row(int x, int y, int z, longint sum, bit oog);
    step_t s;
    s = op_row(m3conv_pkg::CMD_COMPUTE, 0, 0, x, y, z);
    s.typed = 1'b1;
    s.want.sum = sum[SUM_W-1:0];
    s.want.out_of_grid = oog;
    return s;
  endfunction

  task automatic send_item(m3conv_pkg::in_item_t itm, bit typed, m3conv_pkg::out_item_t want);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i <= itm;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    case (itm.command)
      m3conv_pkg::CMD_WRITE_INPUT: begin
        in_mem[itm.address] = itm.sample;
        in_seen[itm.address] = 1'b1;
      end
      m3conv_pkg::CMD_WRITE_FILTER: begin
        flt_mem[itm.address % FILTER_WORDS] = itm.sample;
        flt_seen[itm.address % FILTER_WORDS] = 1'b1;
      end
      m3conv_pkg::CMD_COMPUTE:
        due_points.insert(due_points.size(), typed ? want : conv_point(itm, 1'b0));
      default: ;
    endcase
    if (itm.command != CMD_UNUSED) items_done++;
  endtask

  // a compute is preceded by writes of every word its window reads that holds no data yet
  task automatic run_item(m3conv_pkg::in_item_t itm, bit typed, m3conv_pkg::out_item_t want);
    m3conv_pkg::in_item_t wr;
    if (itm.command == m3conv_pkg::CMD_COMPUTE) begin
      need_in_q.delete();
      need_flt_q.delete();
      void'(conv_point(itm, 1'b1));
      wr = itm;
      foreach (need_in_q[k]) begin
        if (!in_seen[need_in_q[k]]) begin
          wr.command = m3conv_pkg::CMD_WRITE_INPUT;
          wr.address = 12'(need_in_q[k]);
          wr.sample = rand_sample();
          send_item(wr, 1'b0, want);
        end
      end
      foreach (need_flt_q[k]) begin
        if (!flt_seen[need_flt_q[k]]) begin
          wr.command = m3conv_pkg::CMD_WRITE_FILTER;
          wr.address = 12'(need_flt_q[k] + FILTER_WORDS * $urandom_range(0, 3));
          wr.sample = rand_sample();
          send_item(wr, 1'b0, want);
        end
      end
    end
    send_item(itm, typed, want);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    start_i <= 1'b0;
    while (due_points.size() != 0) @(posedge clk_i);
    repeat (IDLE_WAIT) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == m3conv_pkg::CFG_CHANNELS) chan_cnt = val[CC_W-1:0];
    else span_reg[idx] = val;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (due_points.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("result with none pending: sum %0d out_of_grid %0b",
                   result_o.sum, result_o.out_of_grid);
      end else begin
        due_head = due_points.pop_front();
        if (result_o.sum !== due_head.sum) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("sum mismatch: expected %0d got %0d", due_head.sum, result_o.sum);
        end
        if (result_o.out_of_grid !== due_head.out_of_grid) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("out_of_grid mismatch: expected %0b got %0b",
                     due_head.out_of_grid, result_o.out_of_grid);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && busy_o === 1'b0) || done_o === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    m3conv_pkg::in_item_t  itm;
    m3conv_pkg::out_item_t none;
    int                    n;
    int                    ch;
    rst_ni <= 1'b0;
    start_i <= 1'b0;
    in_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= '0;
    none = '0;
    fail_cnt = 0;
    items_done = 0;
    burst = 1'b0;
    for (int a = 0; a < 3; a++) span_reg[a] = m3conv_pkg::SETUP_RESET;
    chan_cnt = m3conv_pkg::CC_RESET;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // unit setup: one sample, one tap, one channel
    add_row(op_row(m3conv_pkg::CMD_WRITE_INPUT, 0, 32767, 0, 0, 0));
    add_row(op_row(m3conv_pkg::CMD_WRITE_FILTER, 0, -32768, 0, 0, 0));
    add_row(chk_row(0, 0, 0, -64'sd1073709056, 1'b0));
    add_row(chk_row(1, 0, 0, 0, 1'b1));
    add_row(chk_row(255, 255, 255, 0, 1'b1));
    add_row(op_row(m3conv_pkg::CMD_WRITE_INPUT, 4095, -1, 0, 0, 0));
    add_row(op_row(m3conv_pkg::CMD_WRITE_INPUT, 0, -32768, 0, 0, 0));
    add_row(op_row(m3conv_pkg::CMD_WRITE_FILTER, 4095, 32767, 0, 0, 0));
    add_row(op_row(m3conv_pkg::CMD_WRITE_FILTER, 3072, -32768, 0, 0, 0));
    add_row(chk_row(0, 0, 0, 64'sd1073741824, 1'b0));
    add_row(op_row(CMD_UNUSED, 4095, -1, 255, 255, 255));
    // channel count of zero, then beyond the maximum
    add_row(cfg_row(m3conv_pkg::CFG_CHANNELS, CFG_W'(0)));
    add_row(chk_row(0, 0, 0, 0, 1'b0));
    add_row(cfg_row(m3conv_pkg::CFG_CHANNELS, CFG_W'(31)));
    add_row(op_row(m3conv_pkg::CMD_COMPUTE, 0, 0, 0, 0, 0));
    add_row(cfg_row(m3conv_pkg::CFG_CHANNELS, CFG_W'(1)));
    // widest x axis, partly off the input
    add_row(cfg_row(m3conv_pkg::CFG_AXIS_X, span_word(255, 15, 7, 7, 255, 255)));
    add_row(op_row(m3conv_pkg::CMD_COMPUTE, 0, 0, 30, 0, 0));
    add_row(chk_row(255, 0, 0, 0, 1'b1));
    // all zero fields with most negative pads
    add_row(cfg_row(m3conv_pkg::CFG_AXIS_X, span_word(0, 0, 0, 0, -256, -256)));
    add_row(chk_row(0, 0, 0, 0, 1'b1));
    // zero taps on a valid grid
    add_row(cfg_row(m3conv_pkg::CFG_AXIS_X, span_word(4, 0, 1, 1, 0, 0)));
    add_row(chk_row(3, 0, 0, 0, 1'b0));
    // zero stride and dilation
    add_row(cfg_row(m3conv_pkg::CFG_AXIS_X, span_word(3, 3, 0, 0, 0, 0)));
    add_row(op_row(m3conv_pkg::CMD_COMPUTE, 0, 0, 200, 0, 0));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].reg_idx, plan[i].reg_val);
      else run_item(plan[i].item, plan[i].typed, plan[i].want);
    end

    while (items_done < ITEM_TARGET) begin
      ch = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3);
      write_reg(m3conv_pkg::CFG_AXIS_X, random_span(ch > 3));
      write_reg(m3conv_pkg::CFG_AXIS_Y, random_span(ch > 3));
      write_reg(m3conv_pkg::CFG_AXIS_Z, random_span(ch > 3));
      write_reg(m3conv_pkg::CFG_CHANNELS, CFG_W'(ch));
      burst = ($urandom_range(0, 3) == 0);
      n = $urandom_range(10, 30);
      repeat (n) begin
        itm.command = m3conv_pkg::CMD_COMPUTE;
        itm.address = 12'($urandom);
        itm.sample = rand_sample();
        itm.out_x = pick_index(span_reg[0]);
        itm.out_y = pick_index(span_reg[1]);
        itm.out_z = pick_index(span_reg[2]);
        case ($urandom_range(0, 9))
          0, 1: itm.command = m3conv_pkg::CMD_WRITE_INPUT;
          2: itm.command = m3conv_pkg::CMD_WRITE_FILTER;
          3: begin
            if ($urandom_range(0, 3) == 0) itm.command = CMD_UNUSED;
            itm.out_x = 8'($urandom);
            itm.out_y = 8'($urandom);
            itm.out_z = 8'($urandom);
          end
          default: ;
        endcase
        run_item(itm, 1'b0, none);
      end
    end

    start_i <= 1'b0;
    while (due_points.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && due_points.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
